// ===== sv/cc20_pkg.sv =====
// Shared types, constants and round functions for the ChaCha20 keystream block.
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;

	// One queued block request: counter value and saturated kept byte count.
	typedef struct packed {
		logic [63:0] ctr;
		logic [6:0]  kept;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	typedef struct packed {
		logic [63:0] key0;
		logic [63:0] key1;
		logic [63:0] key2;
		logic [63:0] key3;
		logic        long_key;
		logic [63:0] nonce;
	} cfg_t;

	localparam logic [2:0] REG_KEY0     = 3'd0;
	localparam logic [2:0] REG_KEY1     = 3'd1;
	localparam logic [2:0] REG_KEY2     = 3'd2;
	localparam logic [2:0] REG_KEY3     = 3'd3;
	localparam logic [2:0] REG_LONG_KEY = 3'd4;
	localparam logic [2:0] REG_NONCE    = 3'd5;

	localparam logic OP_NEXT = 1'b0;
	localparam logic OP_SEEK = 1'b1;

	localparam logic [6:0] KEPT_MAX = 7'd64;

	// "expand 32-byte k" and "expand 16-byte k" as little-endian words.
	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;
	localparam word_t TAU1   = 32'h3120646e;
	localparam word_t TAU2   = 32'h79622d36;

	function automatic word_t rotl(input word_t v, input int unsigned amt);
		rotl = (v << amt) | (v >> (32 - amt));
	endfunction

	// Input block built from the key setup and a counter value.
	function automatic state_t init_state(input cfg_t cfg, input logic [63:0] ctr);
		state_t s;
		logic [63:0] hi0;
		logic [63:0] hi1;
		hi0 = cfg.long_key ? cfg.key2 : cfg.key0;
		hi1 = cfg.long_key ? cfg.key3 : cfg.key1;
		s[0]  = SIGMA0;
		s[1]  = cfg.long_key ? SIGMA1 : TAU1;
		s[2]  = cfg.long_key ? SIGMA2 : TAU2;
		s[3]  = SIGMA3;
		s[4]  = cfg.key0[31:0];
		s[5]  = cfg.key0[63:32];
		s[6]  = cfg.key1[31:0];
		s[7]  = cfg.key1[63:32];
		s[8]  = hi0[31:0];
		s[9]  = hi0[63:32];
		s[10] = hi1[31:0];
		s[11] = hi1[63:32];
		s[12] = ctr[31:0];
		s[13] = ctr[63:32];
		s[14] = cfg.nonce[31:0];
		s[15] = cfg.nonce[63:32];
		return s;
	endfunction

	// Half of a quarter round on all four groups of a column or diagonal round.
	// The first half rotates by 16 and 12, the second half by 8 and 7.
	function automatic state_t half_round(input state_t s, input logic diag,
			input logic second);
		state_t r;
		logic [3:0] ia, ib, ic, id;
		word_t a, b, c, d;
		r = s;
		for (int g = 0; g < 4; g++) begin
			ia = 4'(g);
			ib = diag ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
			ic = diag ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
			id = diag ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
			a = s[ia];
			b = s[ib];
			c = s[ic];
			d = s[id];
			a = a + b;
			d = rotl(d ^ a, second ? 8 : 16);
			c = c + d;
			b = rotl(b ^ c, second ? 7 : 12);
			r[ia] = a;
			r[ib] = b;
			r[ic] = c;
			r[id] = d;
		end
		return r;
	endfunction

endpackage

// ===== sv/cc20_front.sv =====
// Front end: takes request beats, owns the block counter and queues block jobs.
module cc20_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            op,
	input  logic [63:0]     position,
	input  logic [6:0]      kept_bytes,
	input  logic            queue_full,
	output cc20_pkg::push_t push
);

	logic [63:0] ctr_q;
	logic        take;

	assign in_stall = queue_full;
	assign take     = in_valid && !queue_full;

	// Zero kept bytes means no block; counts above 64 are clipped.
	always_comb begin
		push.valid    = take && (op == cc20_pkg::OP_NEXT) && (kept_bytes != 7'd0);
		push.job.ctr  = ctr_q;
		push.job.kept = (kept_bytes > cc20_pkg::KEPT_MAX) ? cc20_pkg::KEPT_MAX : kept_bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= 64'd0;
		end else if (take && op == cc20_pkg::OP_SEEK) begin
			ctr_q <= position;
		end else if (push.valid) begin
			ctr_q <= ctr_q + 64'd1;
		end
	end

endmodule

// ===== sv/cc20_queue.sv =====
// Small job queue between the front end and the round pipeline.
module cc20_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cc20_pkg::push_t push,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output cc20_pkg::job_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	cc20_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("queue count beyond depth");

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("job pushed into a full queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");

endmodule

// ===== sv/cc20_core.sv =====
// Round pipeline: one half quarter round per stage, final add and output register.
module cc20_core #(
	parameter int ROUNDS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cc20_pkg::cfg_t    cfg,
	input  logic              job_valid,
	input  cc20_pkg::job_t    job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output cc20_pkg::state_t  out_block,
	output logic [6:0]        out_kept
);

	localparam int NR = (ROUNDS / 2) * 2;
	localparam int NS = 2 * NR;

	logic              adv;
	logic              vld_s  [NS];
	cc20_pkg::state_t  st_s   [NS];
	logic [63:0]       ctr_s  [NS];
	logic [6:0]        kept_s [NS];
	logic              out_valid_q;
	cc20_pkg::state_t  out_block_q;
	logic [6:0]        out_kept_q;
	cc20_pkg::state_t  fin_init;

	// The whole pipe moves unless a finished block is held by the receiver.
	assign adv     = !out_valid_q || !out_stall;
	assign job_pop = adv && job_valid;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam logic DIAG   = ((k / 2) % 2) == 1;
		localparam logic SECOND = (k % 2) == 1;
		logic             v_in;
		cc20_pkg::state_t s_in;
		logic [63:0]      c_in;
		logic [6:0]       n_in;

		if (k == 0) begin : g_head
			assign v_in = job_valid;
			assign s_in = cc20_pkg::init_state(cfg, job.ctr);
			assign c_in = job.ctr;
			assign n_in = job.kept;
		end else begin : g_body
			assign v_in = vld_s[k-1];
			assign s_in = st_s[k-1];
			assign c_in = ctr_s[k-1];
			assign n_in = kept_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[k]   <= cc20_pkg::half_round(s_in, DIAG, SECOND);
				ctr_s[k]  <= c_in;
				kept_s[k] <= n_in;
			end
		end
	end

	// The user must not change key setup while blocks are in flight; the block
	// does not enforce it. The input block is rebuilt here from the carried counter.
	assign fin_init = cc20_pkg::init_state(cfg, ctr_s[NS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 16; i++) begin
				out_block_q[i] <= st_s[NS-1][i] + fin_init[i];
			end
			out_kept_q <= kept_s[NS-1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_block = out_block_q;
	assign out_kept  = out_kept_q;

endmodule

// ===== sv/chacha20_keystream_block_unit.sv =====
// Top level of the ChaCha20 keystream block unit (64-bit counter and nonce).
//
// Usage: key words, key size and nonce are written over the configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while the unit is idle;
// cfg_ready is always high, so every write beat is accepted.
// Request beats arrive on in_valid/in_stall. A next-block request (op 0)
// with a nonzero kept count produces one 64-byte keystream block for the
// current counter and then advances the counter by one. A seek request
// (op 1) loads the counter and produces nothing. Result beats leave on
// out_valid/out_stall with eight little-endian 64-bit words and the kept
// byte count, clipped to 64.
// Throughput is one block per cycle while out_stall is low. The round
// pipeline has one stage per half quarter round, 4 * (ROUNDS / 2) stages;
// a block goes from its request beat through the job queue, those stages
// and the output register.
// While out_stall holds a result, the whole round pipeline freezes; request
// beats are still taken until the QUEUE_DEPTH job queue fills, then
// in_stall rises. Reset clears the counter, the key and nonce to zero, sets
// the 256-bit key mode and empties the queue and pipeline.
module chacha20_keystream_block_unit #(
	parameter int ROUNDS      = 20,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] position,
	input  logic [6:0]  kept_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] stream_word_0,
	output logic [63:0] stream_word_1,
	output logic [63:0] stream_word_2,
	output logic [63:0] stream_word_3,
	output logic [63:0] stream_word_4,
	output logic [63:0] stream_word_5,
	output logic [63:0] stream_word_6,
	output logic [63:0] stream_word_7,
	output logic [6:0]  valid_bytes
);

	cc20_pkg::cfg_t   cfg_q;
	cc20_pkg::push_t  push;
	cc20_pkg::job_t   head;
	cc20_pkg::state_t block;
	logic             queue_full;
	logic             queue_empty;
	logic             pop;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key0     <= 64'd0;
			cfg_q.key1     <= 64'd0;
			cfg_q.key2     <= 64'd0;
			cfg_q.key3     <= 64'd0;
			cfg_q.long_key <= 1'b1;
			cfg_q.nonce    <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cc20_pkg::REG_KEY0: begin
					cfg_q.key0 <= cfg_data;
				end
				cc20_pkg::REG_KEY1: begin
					cfg_q.key1 <= cfg_data;
				end
				cc20_pkg::REG_KEY2: begin
					cfg_q.key2 <= cfg_data;
				end
				cc20_pkg::REG_KEY3: begin
					cfg_q.key3 <= cfg_data;
				end
				cc20_pkg::REG_LONG_KEY: begin
					cfg_q.long_key <= cfg_data[0];
				end
				cc20_pkg::REG_NONCE: begin
					cfg_q.nonce <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	cc20_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.position   (position),
		.kept_bytes (kept_bytes),
		.queue_full (queue_full),
		.push       (push)
	);

	cc20_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.empty  (queue_empty),
		.head   (head)
	);

	cc20_core #(
		.ROUNDS (ROUNDS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (!queue_empty),
		.job       (head),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_block (block),
		.out_kept  (valid_bytes)
	);

	// Words pair up low word first, giving little-endian byte order.
	assign stream_word_0 = {block[1],  block[0]};
	assign stream_word_1 = {block[3],  block[2]};
	assign stream_word_2 = {block[5],  block[4]};
	assign stream_word_3 = {block[7],  block[6]};
	assign stream_word_4 = {block[9],  block[8]};
	assign stream_word_5 = {block[11], block[10]};
	assign stream_word_6 = {block[13], block[12]};
	assign stream_word_7 = {block[15], block[14]};

	a_kept_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_bytes != 7'd0) && (valid_bytes <= cc20_pkg::KEPT_MAX))
		else $error("result carries a kept count outside one to 64");

	a_seek_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == cc20_pkg::OP_SEEK) |-> !push.valid)
		else $error("seek request queued a block job");

	a_pop_only_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !pop)
		else $error("job taken while the pipeline is frozen");

endmodule
